>>> hdl/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared constants, codes and command/status types of the contingency-table
// chi-square block.
// ----------------------------------------------------------------------------
package ccs_pkg;

  // Table geometry and count width
  localparam int MAX_ROWS     = 16;
  localparam int MAX_COLUMNS  = 16;
  localparam int COUNT_BITS   = 24;
  localparam int CFG_BITS     = 5;
  localparam int CFG_IDX_BITS = 1;
  localparam int ROW_BITS     = $clog2(MAX_ROWS);
  localparam int COL_BITS     = $clog2(MAX_COLUMNS);
  localparam int CELL_DEPTH   = MAX_ROWS * MAX_COLUMNS;
  localparam int ADDR_BITS    = $clog2(CELL_DEPTH);

  // Arithmetic widths
  localparam int SUM_BITS   = 28;   // row and column totals
  localparam int TOTAL_BITS = 32;   // grand total
  localparam int RC_BITS    = 2 * SUM_BITS;        // R*C
  localparam int DIFF_BITS  = 56;                  // |O*T - R*C|
  localparam int DEN_BITS   = TOTAL_BITS + RC_BITS; // T*R*C
  localparam int NUM_BITS   = 2 * DIFF_BITS;       // d^2
  localparam int STAT_BITS  = 48;
  localparam int FRAC_BITS  = 16;
  localparam int LOW_BITS   = 9;
  localparam int DOF_BITS   = 8;
  localparam int DIV_CNT_BITS = $clog2(STAT_BITS + 1);
  localparam int LOW_LIMIT  = 5;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_NUM_ROWS = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_NUM_COLS = 1'd1;

  // Result status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_SIZE   = 2'd1;
  localparam logic [1:0] STATUS_NO_OBS = 2'd2;

  // Multiplier operand selects
  localparam logic [2:0] MUL_RC  = 3'd0;
  localparam logic [2:0] MUL_OT  = 3'd1;
  localparam logic [2:0] MUL_TRL = 3'd2;
  localparam logic [2:0] MUL_TRH = 3'd3;
  localparam logic [2:0] MUL_DLL = 3'd4;
  localparam logic [2:0] MUL_DLH = 3'd5;
  localparam logic [2:0] MUL_DHH = 3'd6;

  // Product accumulation operations
  localparam logic [2:0] ACC_NONE    = 3'd0;
  localparam logic [2:0] ACC_RC      = 3'd1;
  localparam logic [2:0] ACC_OT      = 3'd2;
  localparam logic [2:0] ACC_DEN_LO  = 3'd3;
  localparam logic [2:0] ACC_DEN_HI  = 3'd4;
  localparam logic [2:0] ACC_NUM_LO  = 3'd5;
  localparam logic [2:0] ACC_NUM_MID = 3'd6;
  localparam logic [2:0] ACC_NUM_HI  = 3'd7;

  typedef struct packed {
    logic       load_en;   // store an accepted item
    logic       out_bad;   // load a size-error result
    logic       out_load;  // load the table result
    logic       tbl_clr;   // clear totals and counters
    logic       acc_clr;   // clear statistic and low count
    logic       ram_rd;
    logic [2:0] mul_sel;
    logic [2:0] acc_op;
    logic       d_load;
    logic       low_chk;
    logic       div_init;
    logic       div_step;
    logic       stat_add;
    logic       cnt_step;
  } ccs_cmd_t;

  typedef struct packed {
    logic size_bad;
    logic last_cell;
    logic total_zero;
    logic rc_zero;
    logic div_done;
  } ccs_stat_t;

endpackage

>>> hdl/contingency_chi_square.sv
// ----------------------------------------------------------------------------
// contingency_chi_square
// Pearson chi-square test of independence over a contingency table.
// ----------------------------------------------------------------------------
// Usage:
//   Set the row count (index 0) and the column count (index 1) on the write
//   port; each write clears the partial table. Stream cell counts in row-major
//   order on the s_axis channel, one item a cycle while loading, but the last
//   cell waits while the output register is full. The block then emits one
//   result item on m_axis: statistic in Q32.16, low expected count, degrees of
//   freedom, valid flag and status. A size below two drops each input item
//   and emits a status-only result, which also waits for a free register.
//   Each term uses the shared 32x32 multiplier and the bit-serial divider;
//   a zero R*C adds no term and a saturating term skips the division.
//   Reset restores a 2x2 table with zero totals. While the receiver stalls
//   the result holds in the output register and loading of the next table
//   goes on; a new result waits until the register is free.
// ----------------------------------------------------------------------------
module contingency_chi_square (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ccs_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [ccs_pkg::CFG_BITS-1:0]     cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [23:0]                      s_axis_tdata,  // cell_count[23:0]
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // statistic[47:0], low_cells[56:48], dof[64:57], zeros
  output logic [71:0]                      m_axis_tdata,
  // result_valid[0], status[2:1]
  output logic [2:0]                       m_axis_tuser
);
  import ccs_pkg::*;

  ccs_cmd_t              cmd;
  ccs_stat_t             stat;
  logic [STAT_BITS-1:0]  statistic;
  logic [LOW_BITS-1:0]   low_cells;
  logic [DOF_BITS-1:0]   dof;
  logic                  res_valid;
  logic [1:0]            status;

  ccs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ccs_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cell_count_i   (s_axis_tdata[COUNT_BITS-1:0]),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .statistic_o    (statistic),
    .low_cells_o    (low_cells),
    .dof_o          (dof),
    .result_valid_o (res_valid),
    .status_o       (status)
  );

  // Pack the result item
  assign m_axis_tdata = {7'b0, dof, low_cells, statistic};
  assign m_axis_tuser = {status, res_valid};

  // A computed statistic goes with status ok and nothing else
  a_valid_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tuser[2:1] == STATUS_OK)))
    else $error("result_valid and status disagree");

  // A valid result has at least a 2x2 table
  a_dof_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[64:57] != 8'd0))
    else $error("valid result with zero degrees of freedom");

  // Low expected count never exceeds the table size
  a_low_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[56:48] <= 9'(CELL_DEPTH)))
    else $error("low expected count out of range");

  // No item is taken while the table is being evaluated
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.div_step || cmd.stat_add) |-> !s_axis_tready)
    else $error("input ready during evaluation");

endmodule

>>> hdl/ccs_ram.sv
// ----------------------------------------------------------------------------
// ccs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ccs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/ccs_datapath.sv
// ----------------------------------------------------------------------------
// ccs_datapath
// Table storage, totals, shared 32x32 multiplier, bit-serial divider and
// result registers of the chi-square block.
// ----------------------------------------------------------------------------
module ccs_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ccs_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [ccs_pkg::CFG_BITS-1:0]      cfg_data_i,
  input  logic [ccs_pkg::COUNT_BITS-1:0]    cell_count_i,
  input  ccs_pkg::ccs_cmd_t                 cmd_i,
  output ccs_pkg::ccs_stat_t                stat_o,
  output logic [ccs_pkg::STAT_BITS-1:0]     statistic_o,
  output logic [ccs_pkg::LOW_BITS-1:0]      low_cells_o,
  output logic [ccs_pkg::DOF_BITS-1:0]      dof_o,
  output logic                              result_valid_o,
  output logic [1:0]                        status_o
);
  import ccs_pkg::*;

  // Configuration and geometry
  logic [CFG_BITS-1:0] nrows_q, col_count_q;
  logic [CFG_BITS-1:0] rows, cols;
  logic [ROW_BITS-1:0] rows_m1;
  logic [COL_BITS-1:0] cols_m1;
  logic                size_bad;

  // Table state
  logic [SUM_BITS-1:0]   row_sums_q [MAX_ROWS];
  logic [SUM_BITS-1:0]   col_sums_q [MAX_COLUMNS];
  logic [TOTAL_BITS-1:0] total_q;
  logic [ROW_BITS-1:0]   r_q;
  logic [COL_BITS-1:0]   c_q;
  logic [ADDR_BITS-1:0]  addr_q;
  logic                  last_cell;
  logic                  tbl_clear;

  // Arithmetic state
  logic [COUNT_BITS-1:0]   obs;
  logic [31:0]             mul_a, mul_b;
  logic [63:0]             p_q;
  logic [RC_BITS-1:0]      rc_q;
  logic [DIFF_BITS-1:0]    ot_q, d_q;
  logic [DEN_BITS-1:0]     den_q;
  logic [NUM_BITS-1:0]     num_q;
  logic [DEN_BITS-1:0]     rem_q;
  logic [STAT_BITS-1:0]    quo_q;
  logic [DIV_CNT_BITS-1:0] div_cnt_q;
  logic [STAT_BITS-1:0]    stat_q;
  logic [LOW_BITS-1:0]     low_q;
  logic [DEN_BITS:0]       div_trial;
  logic [DEN_BITS:0]       div_diff;
  logic [STAT_BITS:0]      stat_sum;
  logic [TOTAL_BITS+2:0]   low_limit;

  // Clamp the configured size
  assign rows     = (nrows_q > CFG_BITS'(MAX_ROWS)) ? CFG_BITS'(MAX_ROWS) : nrows_q;
  assign cols     = (col_count_q > CFG_BITS'(MAX_COLUMNS)) ? CFG_BITS'(MAX_COLUMNS)
                                                           : col_count_q;
  assign rows_m1  = ROW_BITS'(rows - CFG_BITS'(1));
  assign cols_m1  = COL_BITS'(cols - CFG_BITS'(1));
  assign size_bad = (rows < CFG_BITS'(2)) || (cols < CFG_BITS'(2));
  assign last_cell = (r_q == rows_m1) && (c_q == cols_m1);
  assign tbl_clear = cmd_i.tbl_clr || cfg_we_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrows_q     <= CFG_BITS'(2);
      col_count_q <= CFG_BITS'(2);
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_NUM_ROWS) begin
        nrows_q <= cfg_data_i;
      end else begin
        col_count_q <= cfg_data_i;
      end
    end
  end

  // Accumulate totals and walk the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ROWS; i++) row_sums_q[i] <= '0;
      for (int i = 0; i < MAX_COLUMNS; i++) col_sums_q[i] <= '0;
      total_q <= '0;
      r_q     <= '0;
      c_q     <= '0;
      addr_q  <= '0;
    end else if (tbl_clear) begin
      for (int i = 0; i < MAX_ROWS; i++) row_sums_q[i] <= '0;
      for (int i = 0; i < MAX_COLUMNS; i++) col_sums_q[i] <= '0;
      total_q <= '0;
      r_q     <= '0;
      c_q     <= '0;
      addr_q  <= '0;
    end else begin
      if (cmd_i.load_en) begin
        row_sums_q[r_q] <= row_sums_q[r_q] + SUM_BITS'(cell_count_i);
        col_sums_q[c_q] <= col_sums_q[c_q] + SUM_BITS'(cell_count_i);
        total_q         <= total_q + TOTAL_BITS'(cell_count_i);
      end
      if (cmd_i.load_en || cmd_i.cnt_step) begin
        if (last_cell) begin
          r_q    <= '0;
          c_q    <= '0;
          addr_q <= '0;
        end else begin
          addr_q <= addr_q + ADDR_BITS'(1);
          if (c_q == cols_m1) begin
            c_q <= '0;
            r_q <= r_q + ROW_BITS'(1);
          end else begin
            c_q <= c_q + COL_BITS'(1);
          end
        end
      end
    end
  end

  // Cell store
  ccs_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (CELL_DEPTH)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_en),
    .waddr_i (addr_q),
    .wdata_i (cell_count_i),
    .re_i    (cmd_i.ram_rd),
    .raddr_i (addr_q),
    .rdata_o (obs)
  );

  // Select multiplier operands
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_RC: begin
        mul_a = 32'(row_sums_q[r_q]);
        mul_b = 32'(col_sums_q[c_q]);
      end
      MUL_OT: begin
        mul_a = 32'(obs);
        mul_b = total_q;
      end
      MUL_TRL: begin
        mul_a = total_q;
        mul_b = rc_q[31:0];
      end
      MUL_TRH: begin
        mul_a = total_q;
        mul_b = 32'(rc_q[RC_BITS-1:32]);
      end
      MUL_DLL: begin
        mul_a = d_q[31:0];
        mul_b = d_q[31:0];
      end
      MUL_DLH: begin
        mul_a = d_q[31:0];
        mul_b = 32'(d_q[DIFF_BITS-1:32]);
      end
      MUL_DHH: begin
        mul_a = 32'(d_q[DIFF_BITS-1:32]);
        mul_b = 32'(d_q[DIFF_BITS-1:32]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Register each product
  always_ff @(posedge clk_i) begin
    p_q <= 64'(mul_a) * 64'(mul_b);
  end

  // Fold products into R*C, O*T, T*R*C and d^2
  always_ff @(posedge clk_i) begin
    case (cmd_i.acc_op)
      ACC_RC:      rc_q  <= RC_BITS'(p_q);
      ACC_OT:      ot_q  <= DIFF_BITS'(p_q);
      ACC_DEN_LO:  den_q <= DEN_BITS'(p_q);
      ACC_DEN_HI:  den_q <= den_q + (DEN_BITS'(p_q) << 32);
      ACC_NUM_LO:  num_q <= NUM_BITS'(p_q);
      ACC_NUM_MID: num_q <= num_q + (NUM_BITS'(p_q) << 33);
      ACC_NUM_HI:  num_q <= num_q + (NUM_BITS'(p_q) << 64);
      default: ;
    endcase
    if (cmd_i.d_load) begin
      d_q <= (ot_q >= rc_q) ? (ot_q - rc_q) : (rc_q - ot_q);
    end
  end

  // Divide 2^16 * d^2 by T*R*C, one quotient bit a cycle
  assign div_trial = {rem_q, quo_q[STAT_BITS-1]};
  assign div_diff  = div_trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_init) begin
      if (DEN_BITS'(num_q[NUM_BITS-1:32]) >= den_q) begin
        div_cnt_q <= '0;
      end else begin
        div_cnt_q <= DIV_CNT_BITS'(STAT_BITS);
      end
    end else if (cmd_i.div_step && (div_cnt_q != '0)) begin
      div_cnt_q <= div_cnt_q - DIV_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      // Quotient of 2^48 or more saturates at once
      if (DEN_BITS'(num_q[NUM_BITS-1:32]) >= den_q) begin
        quo_q <= '1;
      end else begin
        rem_q <= DEN_BITS'(num_q[NUM_BITS-1:32]);
        quo_q <= {num_q[31:0], {FRAC_BITS{1'b0}}};
      end
    end else if (cmd_i.div_step && (div_cnt_q != '0)) begin
      if (!div_diff[DEN_BITS]) begin
        rem_q <= DEN_BITS'(div_diff);
        quo_q <= {quo_q[STAT_BITS-2:0], 1'b1};
      end else begin
        rem_q <= DEN_BITS'(div_trial);
        quo_q <= {quo_q[STAT_BITS-2:0], 1'b0};
      end
    end
  end

  // Sum terms with saturation and count low expected cells
  assign stat_sum  = {1'b0, stat_q} + {1'b0, quo_q};
  assign low_limit = {1'b0, total_q, 2'b00} + (TOTAL_BITS+3)'(total_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_q <= '0;
      low_q  <= '0;
    end else if (cmd_i.acc_clr) begin
      stat_q <= '0;
      low_q  <= '0;
    end else begin
      if (cmd_i.stat_add) begin
        stat_q <= stat_sum[STAT_BITS] ? '1 : stat_sum[STAT_BITS-1:0];
      end
      if (cmd_i.low_chk && (rc_q < RC_BITS'(low_limit))) begin
        low_q <= low_q + LOW_BITS'(1);
      end
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_bad) begin
      statistic_o    <= '0;
      low_cells_o    <= '0;
      dof_o          <= '0;
      result_valid_o <= 1'b0;
      status_o       <= STATUS_SIZE;
    end else if (cmd_i.out_load) begin
      if (total_q == '0) begin
        statistic_o    <= '0;
        low_cells_o    <= '0;
        dof_o          <= '0;
        result_valid_o <= 1'b0;
        status_o       <= STATUS_NO_OBS;
      end else begin
        statistic_o    <= stat_q;
        low_cells_o    <= low_q;
        dof_o          <= DOF_BITS'(rows_m1) * DOF_BITS'(cols_m1);
        result_valid_o <= 1'b1;
        status_o       <= STATUS_OK;
      end
    end
  end

  assign stat_o.size_bad   = size_bad;
  assign stat_o.last_cell  = last_cell;
  assign stat_o.total_zero = (total_q == '0);
  assign stat_o.rc_zero    = (rc_q == '0);
  assign stat_o.div_done   = (div_cnt_q == '0);

endmodule

>>> hdl/ccs_ctrl.sv
// ----------------------------------------------------------------------------
// ccs_ctrl
// Sequencer of the chi-square block: loads the table, steps the per-cell
// term computation and hands results to the output register.
// ----------------------------------------------------------------------------
module ccs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  ccs_pkg::ccs_stat_t stat_i,
  output ccs_pkg::ccs_cmd_t  cmd_o
);
  import ccs_pkg::*;

  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;
  localparam logic [3:0] S_RD       = 4'd2;
  localparam logic [3:0] S_M_RC     = 4'd3;
  localparam logic [3:0] S_M_OT     = 4'd4;
  localparam logic [3:0] S_M_TRL    = 4'd5;
  localparam logic [3:0] S_M_TRH    = 4'd6;
  localparam logic [3:0] S_M_DLL    = 4'd7;
  localparam logic [3:0] S_M_DLH    = 4'd8;
  localparam logic [3:0] S_M_DHH    = 4'd9;
  localparam logic [3:0] S_ACC_HI   = 4'd10;
  localparam logic [3:0] S_DIV_INIT = 4'd11;
  localparam logic [3:0] S_DIV      = 4'd12;
  localparam logic [3:0] S_ADD      = 4'd13;
  localparam logic [3:0] S_NEXT     = 4'd14;
  localparam logic [3:0] S_EMIT     = 4'd15;

  logic [3:0] state_q, state_d;
  logic       out_valid_q;
  logic       out_room;
  logic       accept;

  assign out_room   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_LOAD) &&
                      (out_room || (!stat_i.size_bad && !stat_i.last_cell));
  assign accept     = in_valid_i && in_ready_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_sel = MUL_RC;
    cmd_o.acc_op  = ACC_NONE;
    case (state_q)
      S_LOAD: begin
        if (accept) begin
          if (stat_i.size_bad) begin
            cmd_o.out_bad = 1'b1;
          end else begin
            cmd_o.load_en = 1'b1;
            if (stat_i.last_cell) state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        cmd_o.acc_clr = 1'b1;
        state_d = stat_i.total_zero ? S_EMIT : S_RD;
      end
      S_RD: begin
        cmd_o.ram_rd = 1'b1;
        state_d = S_M_RC;
      end
      S_M_RC: begin
        cmd_o.mul_sel = MUL_RC;
        state_d = S_M_OT;
      end
      S_M_OT: begin
        cmd_o.mul_sel = MUL_OT;
        cmd_o.acc_op  = ACC_RC;
        state_d = S_M_TRL;
      end
      S_M_TRL: begin
        cmd_o.mul_sel = MUL_TRL;
        cmd_o.acc_op  = ACC_OT;
        state_d = S_M_TRH;
      end
      S_M_TRH: begin
        cmd_o.mul_sel = MUL_TRH;
        cmd_o.acc_op  = ACC_DEN_LO;
        cmd_o.d_load  = 1'b1;
        cmd_o.low_chk = 1'b1;
        // Zero expected count adds no term
        state_d = stat_i.rc_zero ? S_NEXT : S_M_DLL;
      end
      S_M_DLL: begin
        cmd_o.mul_sel = MUL_DLL;
        cmd_o.acc_op  = ACC_DEN_HI;
        state_d = S_M_DLH;
      end
      S_M_DLH: begin
        cmd_o.mul_sel = MUL_DLH;
        cmd_o.acc_op  = ACC_NUM_LO;
        state_d = S_M_DHH;
      end
      S_M_DHH: begin
        cmd_o.mul_sel = MUL_DHH;
        cmd_o.acc_op  = ACC_NUM_MID;
        state_d = S_ACC_HI;
      end
      S_ACC_HI: begin
        cmd_o.acc_op = ACC_NUM_HI;
        state_d = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_done) state_d = S_ADD;
      end
      S_ADD: begin
        cmd_o.stat_add = 1'b1;
        state_d = S_NEXT;
      end
      S_NEXT: begin
        if (stat_i.last_cell) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.cnt_step = 1'b1;
          state_d = S_RD;
        end
      end
      S_EMIT: begin
        if (out_room) begin
          cmd_o.out_load = 1'b1;
          cmd_o.tbl_clr  = 1'b1;
          state_d = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold a result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_o.out_bad || cmd_o.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
